// File: rtl/lph_pkg.sv
// Shared types and constants for the linear-probe hash table.
// Holds the table geometry, request and status codes and the microcode word layout.
// Depends on nothing; every other file imports it.
package lph_pkg;

	localparam int TABLE_SIZE = 13;
	localparam int KEY_W      = 31;
	localparam int SLOT_W     = $clog2(TABLE_SIZE + 1);
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int CNT_W      = $clog2(TABLE_SIZE);

	// The home slot is found four key bits per step.
	localparam int NIB_W     = 4;
	localparam int NIB_STEPS = (KEY_W + NIB_W - 1) / NIB_W;
	localparam int SHIFT_W   = NIB_STEPS * NIB_W;
	localparam int NIBCNT_W  = $clog2(NIB_STEPS);

	localparam logic [1:0] OP_SEARCH = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_DUP       = 2'd3;

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
	localparam logic [STEP_W-1:0] STEP_MOD    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_PROBE  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_FINISH = 3'd4;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_XFER,
		COND_MOD_LAST,
		COND_EARLY,
		COND_PROBE_END,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		logic              accept;
		logic              mod_step;
		logic              start_probe;
		logic              probe;
		logic              commit;
		cond_t             cond;
		logic              hold;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic in_xfer;
		logic mod_last;
		logic early;
		logic probe_end;
		logic out_free;
	} flags_t;

endpackage

// File: rtl/lph_seq.sv
// Microcode sequencer for the linear-probe hash table.
// Holds the program ROM and the step counter; uses lph_pkg.
module lph_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  lph_pkg::flags_t flags,
	output lph_pkg::ucode_t uc
);
	import lph_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              cond_true;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '0;
		unique case (step)
			STEP_IDLE: begin
				w.accept = 1'b1;
				w.cond   = COND_IN_XFER;
				w.hold   = 1'b1;
				w.target = STEP_MOD;
			end
			STEP_MOD: begin
				w.mod_step = 1'b1;
				w.cond     = COND_MOD_LAST;
				w.hold     = 1'b1;
				w.target   = STEP_LOAD;
			end
			STEP_LOAD: begin
				w.start_probe = 1'b1;
				w.cond        = COND_EARLY;
				w.target      = STEP_FINISH;
			end
			STEP_PROBE: begin
				w.probe  = 1'b1;
				w.cond   = COND_PROBE_END;
				w.hold   = 1'b1;
				w.target = STEP_FINISH;
			end
			STEP_FINISH: begin
				w.commit = 1'b1;
				w.cond   = COND_OUT_FREE;
				w.hold   = 1'b1;
				w.target = STEP_IDLE;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	assign uc = ucode_rom(step_q);

	always_comb begin
		unique case (uc.cond)
			COND_ALWAYS:    cond_true = 1'b1;
			COND_IN_XFER:   cond_true = flags.in_xfer;
			COND_MOD_LAST:  cond_true = flags.mod_last;
			COND_EARLY:     cond_true = flags.early;
			COND_PROBE_END: cond_true = flags.probe_end;
			COND_OUT_FREE:  cond_true = flags.out_free;
			default:        cond_true = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (cond_true) begin
			step_q <= uc.target;
		end else if (!uc.hold) begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// File: rtl/linear_probe_hash_table_top.sv
// Linear-probe hash table: search, insert and remove of nonzero 31-bit keys.
// A request passes the home slot reduction, four key bits a step, then the probe walk,
// one slot per cycle, unless it is settled before probing. The next request is taken
// only after the result has been loaded into the output register, so requests never
// overlap inside the block.
// Reset empties the table at once through per-slot valid flags; no clearing pass is needed.
module linear_probe_hash_table_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [lph_pkg::KEY_W-1:0]   key,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [lph_pkg::SLOT_W-1:0]  slot,
	output logic [lph_pkg::CNT_W-1:0]   key_count
);
	import lph_pkg::*;

	localparam logic [CNT_W-1:0]    CNT_MAX   = CNT_W'(TABLE_SIZE - 1);
	localparam logic [ADDR_W-1:0]   ADDR_LAST = ADDR_W'(TABLE_SIZE - 1);
	localparam logic [SLOT_W-1:0]   SLOT_NONE = SLOT_W'(TABLE_SIZE);
	localparam logic [ADDR_W:0]     MOD_N     = (ADDR_W + 1)'(TABLE_SIZE);
	localparam logic [NIBCNT_W-1:0] NIB_LAST  = NIBCNT_W'(NIB_STEPS - 1);

	ucode_t uc;
	flags_t flags;

	// Request registers, loaded on the input transfer.
	logic [1:0]          op_q;
	logic [KEY_W-1:0]    key_q;

	// Home slot reduction: the key is shifted out four bits a step into a running remainder.
	logic [SHIFT_W-1:0]  sh_q;
	logic [ADDR_W-1:0]   rem_q;
	logic [NIBCNT_W-1:0] nib_q;
	logic [ADDR_W:0]     rem_acc;
	logic [ADDR_W-1:0]   rem_next;

	// Probe state and the table itself.
	logic [ADDR_W-1:0]     pos_q;
	logic [ADDR_W-1:0]     probes_q;
	logic [ADDR_W-1:0]     pos_inc;
	logic [ADDR_W-1:0]     rd_addr;
	logic [KEY_W-1:0]      rd_key_q;
	logic                  rd_vld_q;
	logic [TABLE_SIZE-1:0] vld_q;
	logic [KEY_W-1:0]      slot_mem [TABLE_SIZE];
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_next;

	logic hit;
	logic empty;
	logic exhausted;
	logic op_known;

	// Result held between the probe and the commit step.
	logic [1:0]        res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              wr_en_q;
	logic              wr_set_q;
	logic              commit_go;

	// Output register: it parts the result from the next request.
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  key_count_q;

	lph_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uc     (uc)
	);

	assign in_ready  = uc.accept;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign key_count = key_count_q;

	// Each remainder step folds in one key bit; one compare and subtract keeps it below
	// the table size because twice the remainder plus one stays below twice the size.
	always_comb begin
		rem_acc = {1'b0, rem_q};
		for (int i = 0; i < NIB_W; i++) begin
			rem_acc = {rem_acc[ADDR_W-1:0], sh_q[SHIFT_W-1-i]};
			if (rem_acc >= MOD_N) begin
				rem_acc = rem_acc - MOD_N;
			end
		end
		rem_next = rem_acc[ADDR_W-1:0];
	end

	assign pos_inc   = (pos_q == ADDR_LAST) ? '0 : pos_q + 1'b1;
	assign rd_addr   = uc.start_probe ? rem_q : pos_inc;
	assign hit       = rd_vld_q && (rd_key_q == key_q);
	assign empty     = !rd_vld_q;
	assign exhausted = (probes_q == ADDR_LAST);
	assign op_known  = (op_q == OP_SEARCH) || (op_q == OP_INSERT) || (op_q == OP_REMOVE);

	// A zero key or an unknown request answers not found without probing, and an insert
	// into a table that already holds its limit answers full without probing.
	assign flags.in_xfer   = in_valid && uc.accept;
	assign flags.mod_last  = (nib_q == NIB_LAST);
	assign flags.early     = (key_q == '0) || !op_known ||
	                         ((op_q == OP_INSERT) && (count_q == CNT_MAX));
	assign flags.probe_end = hit || empty || exhausted;
	assign flags.out_free  = !out_valid_q || out_ready;

	assign commit_go = uc.commit && flags.out_free;

	always_comb begin
		count_next = count_q;
		if (wr_en_q) begin
			if (wr_set_q) begin
				count_next = count_q + 1'b1;
			end else begin
				count_next = count_q - 1'b1;
			end
		end
	end

	// Request capture, home slot reduction and the probe walk.
	always_ff @(posedge clk) begin
		if (flags.in_xfer) begin
			op_q  <= op;
			key_q <= key;
			sh_q  <= SHIFT_W'(key);
			rem_q <= '0;
			nib_q <= '0;
		end
		if (uc.mod_step) begin
			sh_q  <= sh_q << NIB_W;
			rem_q <= rem_next;
			nib_q <= nib_q + 1'b1;
		end
		if (uc.start_probe) begin
			pos_q        <= rem_q;
			probes_q     <= '0;
			res_slot_q   <= SLOT_NONE;
			wr_set_q     <= 1'b0;
			if (op_known && (key_q != '0) && (op_q == OP_INSERT) && (count_q == CNT_MAX)) begin
				res_status_q <= ST_FULL;
			end else begin
				res_status_q <= ST_NOT_FOUND;
			end
		end
		if (uc.probe) begin
			if (!flags.probe_end) begin
				pos_q    <= pos_inc;
				probes_q <= probes_q + 1'b1;
			end else begin
				case (op_q)
					OP_SEARCH: begin
						if (hit) begin
							res_status_q <= ST_OK;
							res_slot_q   <= SLOT_W'(pos_q);
						end
					end
					OP_INSERT: begin
						if (hit) begin
							res_status_q <= ST_DUP;
						end else if (empty) begin
							res_status_q <= ST_OK;
							res_slot_q   <= SLOT_W'(pos_q);
							wr_set_q     <= 1'b1;
						end else begin
							res_status_q <= ST_FULL;
						end
					end
					OP_REMOVE: begin
						if (hit) begin
							res_status_q <= ST_OK;
							res_slot_q   <= SLOT_W'(pos_q);
						end
					end
					default: begin
						res_status_q <= ST_NOT_FOUND;
					end
				endcase
			end
		end
	end

	// The write intent is control: it must never fire a commit that a probe did not set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_q <= 1'b0;
		end else if (uc.start_probe) begin
			wr_en_q <= 1'b0;
		end else if (uc.probe && flags.probe_end) begin
			wr_en_q <= hit ? (op_q == OP_REMOVE) : (empty && (op_q == OP_INSERT));
		end
	end

	// Key store with registered read; one slot is read per cycle.
	always_ff @(posedge clk) begin
		rd_key_q <= slot_mem[rd_addr];
		rd_vld_q <= vld_q[rd_addr];
		if (commit_go && wr_en_q && wr_set_q) begin
			slot_mem[pos_q] <= key_q;
		end
	end

	// Slot occupancy and key count. A removed slot simply becomes empty again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			count_q <= '0;
		end else if (commit_go) begin
			count_q <= count_next;
			if (wr_en_q) begin
				vld_q[pos_q] <= wr_set_q;
			end
		end
	end

	// Output register: loaded at commit, emptied by a transfer on the result side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			status_q    <= res_status_q;
			slot_q      <= res_slot_q;
			key_count_q <= count_next;
		end
	end

	// The key count never reaches the table size, so one slot always stays empty.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("key count beyond limit");

	// The key count always equals the number of occupied slots.
	a_count_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_q) == int'(count_q))
		else $error("key count disagrees with occupancy");

	// An insert only fills an empty slot and a remove only clears an occupied one.
	a_write_target: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_go && wr_en_q) |-> (vld_q[pos_q] == !wr_set_q))
		else $error("table write to wrong kind of slot");

	// Reads during a probe stay inside the table.
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		(uc.start_probe || uc.probe) |-> (rd_addr <= ADDR_LAST))
		else $error("probe address outside table");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the linear-probe hash table (search, insert, remove).
// A directed sequence and then biased random requests go through the valid/ready ports.
// Each result is checked against an in-bench model of the table. Depends on lph_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lph_pkg::*;

	localparam int          NO_SLOT      = TABLE_SIZE;
	localparam logic [1:0]  OP_UNDEFINED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam int          RANDOM_ITEMS = 1700;
	localparam int          POOL_SIZE    = 24;

	// One request waiting to be driven. A request marked drain_first is held back until
	// every result already owed by the block has come out.
	typedef struct {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		bit               drain_first;
	} request_t;

	typedef struct {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  key_count;
	} answer_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        op;
	logic [KEY_W-1:0]  key;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot;
	logic [CNT_W-1:0]  key_count;

	linear_probe_hash_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.slot      (slot),
		.key_count (key_count)
	);

	request_t         pending_requests[$];
	answer_t          owed_answers[$];
	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	// Model of the table contents. A zero entry marks an empty slot.
	logic [KEY_W-1:0] table_keys[TABLE_SIZE];
	int               held_keys;

	int mismatch_count;
	int transfers_in;
	bit request_taken;

	// Idling odds, in per cent, for the sender and the receiver.
	int sender_idle_pct;
	int receiver_idle_pct;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int home_slot(input logic [KEY_W-1:0] k);
		return int'({1'b0, k} % 32'(TABLE_SIZE));
	endfunction

	// Walks forward from the home slot and stops at the key or at the first empty slot.
	// An empty table answers at once.
	function automatic int probe_for_key(input logic [KEY_W-1:0] k);
		int pos;
		if (held_keys == 0)
			return NO_SLOT;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			pos = (home_slot(k) + i) % TABLE_SIZE;
			if (table_keys[pos] == k)
				return pos;
			if (table_keys[pos] == '0)
				return NO_SLOT;
		end
		return NO_SLOT;
	endfunction

	function automatic int first_empty_from(input logic [KEY_W-1:0] k);
		int pos;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			pos = (home_slot(k) + i) % TABLE_SIZE;
			if (table_keys[pos] == '0)
				return pos;
		end
		return NO_SLOT;
	endfunction

	// Applies one accepted request to the model table and queues the answer it owes.
	// Key zero and the undefined operation leave the table alone and answer not found.
	task automatic apply_request(input logic [1:0] req_op, input logic [KEY_W-1:0] req_key);
		answer_t a;
		int      pos;
		a.status = ST_NOT_FOUND;
		pos = NO_SLOT;
		if (req_key != '0) begin
			case (req_op)
				OP_SEARCH: begin
					pos = probe_for_key(req_key);
					if (pos < TABLE_SIZE)
						a.status = ST_OK;
				end
				OP_INSERT: begin
					// A full table is reported before a duplicate key.
					if (held_keys == TABLE_SIZE - 1) begin
						a.status = ST_FULL;
					end else if (probe_for_key(req_key) < TABLE_SIZE) begin
						a.status = ST_DUP;
					end else begin
						pos = first_empty_from(req_key);
						if (pos < TABLE_SIZE) begin
							table_keys[pos] = req_key;
							held_keys++;
							a.status = ST_OK;
						end else begin
							a.status = ST_FULL;
						end
					end
				end
				OP_REMOVE: begin
					// The slot simply becomes empty, so keys probed past it are lost.
					pos = probe_for_key(req_key);
					if (pos < TABLE_SIZE) begin
						table_keys[pos] = '0;
						if (held_keys > 0)
							held_keys--;
						a.status = ST_OK;
					end
				end
				default: ;
			endcase
		end
		if (a.status != ST_OK)
			pos = NO_SLOT;
		a.slot = SLOT_W'(pos);
		a.key_count = CNT_W'(held_keys);
		owed_answers.push_back(a);
	endtask

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	task automatic queue_request(input logic [1:0] o, input logic [KEY_W-1:0] k,
			input bit drain = 1'b0);
		request_t r;
		r.op = o;
		r.key = k;
		r.drain_first = drain;
		pending_requests.push_back(r);
	endtask

	// Keys are drawn mostly from a small pool, so that inserts, searches and removes
	// keep meeting each other. Half the pool is packed into a few neighbouring home slots
	// to build long probe chains; the rest spreads over the whole key range.
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 72)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (roll < 95)
			return KEY_W'($urandom_range(1, 32'h7fff_ffff));
		else
			return '0;
	endfunction

	task automatic build_random_requests();
		int insert_pct;
		int roll;
		logic [1:0] o;
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i < POOL_SIZE / 2)
				key_pool[i] = KEY_W'(TABLE_SIZE * $urandom_range(1, 5000)
					+ $urandom_range(0, 3));
			else
				key_pool[i] = KEY_W'($urandom_range(1, 32'h7fff_ffff));
		end
		insert_pct = 50;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Every hundred requests the insert bias moves, so the table fills up and
			// drains again several times over the run.
			if (i % 100 == 0)
				insert_pct = 20 + 30 * $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			if (roll < 4)
				o = OP_UNDEFINED;
			else if (roll < 4 + insert_pct)
				o = OP_INSERT;
			else if ($urandom_range(0, 1) == 0)
				o = OP_SEARCH;
			else
				o = OP_REMOVE;
			queue_request(o, pick_key(), (i % 400) == 0);
		end
	endtask

	// Sender and receiver. Everything the block sees changes on the falling edge. A request
	// stays on the port, unchanged, until the transfer has been seen at a rising edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
			if (!in_valid || request_taken) begin
				request_taken = 1'b0;
				if (pending_requests.size() == 0
						|| $urandom_range(0, 99) < sender_idle_pct
						|| (pending_requests[0].drain_first && owed_answers.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					op       <= pending_requests[0].op;
					key      <= pending_requests[0].key;
					in_valid <= 1'b1;
					void'(pending_requests.pop_front());
				end
			end
		end
	end

	// Idling follows the number of input transfers: receiver-heavy stalls first, then
	// sender-heavy gaps, then a stretch at full rate.
	always @(transfers_in) begin
		if (transfers_in < 600) begin
			sender_idle_pct   = 34;
			receiver_idle_pct = 71;
		end else if (transfers_in < 1200) begin
			sender_idle_pct   = 71;
			receiver_idle_pct = 34;
		end else begin
			sender_idle_pct   = 0;
			receiver_idle_pct = 0;
		end
	end

	// Observer. Both handshakes are sampled on the rising edge, before the block's own
	// registers move, so the values seen are those that made the transfer.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_request(op, key);
				request_taken = 1'b1;
				transfers_in++;
			end
			if (out_valid && out_ready) begin
				if (owed_answers.size() == 0) begin
					note_mismatch($sformatf("result with none owed: status %0d slot %0d count %0d",
						status, slot, key_count));
				end else begin
					want = owed_answers.pop_front();
					if (status !== want.status || slot !== want.slot
							|| key_count !== want.key_count)
						note_mismatch($sformatf(
							"expected status %0d slot %0d count %0d, got %0d %0d %0d",
							want.status, want.slot, want.key_count,
							status, slot, key_count));
				end
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		out_ready      = 1'b0;
		op             = OP_SEARCH;
		key            = '0;
		mismatch_count = 0;
		held_keys      = 0;
		request_taken  = 1'b0;
		transfers_in   = 0;
		sender_idle_pct   = 34;
		receiver_idle_pct = 71;
		for (int i = 0; i < TABLE_SIZE; i++)
			table_keys[i] = '0;

		// Directed opening: an empty table, key zero and the undefined operation.
		queue_request(OP_SEARCH, 31'd5);
		queue_request(OP_REMOVE, 31'd5);
		queue_request(OP_INSERT, '0);
		queue_request(OP_UNDEFINED, 31'd7);
		// The largest key, then a chain of three keys sharing one home slot.
		queue_request(OP_INSERT, KEY_MAX);
		queue_request(OP_INSERT, 31'd1);
		queue_request(OP_INSERT, 31'd14);
		queue_request(OP_INSERT, 31'd27);
		queue_request(OP_INSERT, 31'd14);
		queue_request(OP_SEARCH, 31'd27);
		// Clearing the middle of the chain hides the key beyond it.
		queue_request(OP_REMOVE, 31'd14);
		queue_request(OP_SEARCH, 31'd27);
		// A probe that wraps from the last slot round to slot zero.
		queue_request(OP_INSERT, 31'd12);
		queue_request(OP_INSERT, 31'd25);
		queue_request(OP_SEARCH, 31'd25);
		queue_request(OP_SEARCH, '0);
		queue_request(OP_REMOVE, '0);
		queue_request(OP_UNDEFINED, KEY_MAX);
		// Fill to one short of the table size; further inserts are refused as full,
		// even when the key is already held.
		for (int k = 2; k <= 9; k++)
			if (k != 3)
				queue_request(OP_INSERT, KEY_W'(k));
		queue_request(OP_INSERT, 31'd100);
		queue_request(OP_INSERT, 31'd1);
		build_random_requests();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || in_valid)
			@(posedge clk);
		while (owed_answers.size() != 0)
			@(posedge clk);
		// Let any stray result show itself before judging the run.
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
rtl/lph_pkg.sv
rtl/lph_seq.sv
rtl/linear_probe_hash_table_top.sv
tb/tb.sv
